FILE: hw/rtl/sdm_pkg.sv
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared types and constants of the symbol name demangler.
// ----------------------------------------------------------------------------
package sdm_pkg;

	localparam int COMP_MAX   = 32;
	localparam int IDX_W      = $clog2(COMP_MAX);
	localparam int REP_W      = $clog2(COMP_MAX + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [15:0] CAP_RESET = 16'd256;

	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_UV    = 8'h56;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Output work for one input byte, in emission order:
	// colons, tilde, text char, replayed component, closing status.
	typedef struct packed {
		logic [1:0]       col;
		logic             tilde;
		logic             ch_v;
		logic [7:0]       ch;
		logic [REP_W-1:0] rep_n;
		logic             fin_v;
		logic             fail;
		logic [15:0]      len;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} st_wr_t;

	typedef struct packed {
		logic replay_done;
	} bk_status_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic        fail;
		logic [15:0] len;
		logic        last;
	} res_t;

endpackage

FILE: hw/rtl/sdm_front.sv
// ----------------------------------------------------------------------------
// sdm_front
// Parser: accepts mangled bytes, tracks the name grammar and output room,
// and queues the output work each byte causes.
// ----------------------------------------------------------------------------
module sdm_front import sdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output cmd_t        cmd,
	output logic        cmd_push,
	input  logic        fifo_full,
	input  bk_status_t  bk_status,
	output st_wr_t      st_wr
);

	typedef enum logic [8:0] {
		PH_UNDERSCORE = 9'b000000001,
		PH_Z          = 9'b000000010,
		PH_AFTER_Z    = 9'b000000100,
		PH_QUALS      = 9'b000001000,
		PH_DIGITS     = 9'b000010000,
		PH_TEXT       = 9'b000100000,
		PH_AFTER_COMP = 9'b001000000,
		PH_DONE       = 9'b010000000,
		PH_FAILED     = 9'b100000000
	} phase_t;

	phase_t           phase_q, ph_n;
	logic [15:0]      dv_q, dv_n;
	logic [15:0]      bl_q, bl_n;
	logic [15:0]      ec_q, ec_n;
	logic [REP_W-1:0] fill_q, fill_n;
	logic             nest_q, nest_n;
	logic [15:0]      cap_q;
	logic             replay_q;

	logic             accept;
	logic             do_end, do_after, do_start, do_text;
	logic             is_dig;
	logic [3:0]       dval;
	logic [19:0]      acc;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             has_out;
	cmd_t             c;

	function automatic logic room(input logic [15:0] cnt, input logic [16:0] n,
			input logic [15:0] cap);
		room = ({1'b0, cnt} + n + 17'd1) <= {1'b0, cap};
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = !fifo_full && !replay_q;
	assign is_dig   = (in_byte inside {[CH_0:CH_9]});
	assign dval     = 4'(in_byte - CH_0);
	assign acc      = ({4'b0, dv_q} << 3) + ({4'b0, dv_q} << 1) + 20'(dval);

	always_comb begin
		ph_n     = phase_q;
		dv_n     = dv_q;
		bl_n     = bl_q;
		ec_n     = ec_q;
		fill_n   = fill_q;
		nest_n   = nest_q;
		do_end   = 1'b0;
		do_after = 1'b0;
		do_start = 1'b0;
		do_text  = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		c        = '0;

		case (phase_q)
			PH_UNDERSCORE: ph_n = (in_byte == CH_US) ? PH_Z : PH_FAILED;
			PH_Z:          ph_n = (in_byte == CH_Z) ? PH_AFTER_Z : PH_FAILED;
			PH_AFTER_Z: begin
				if (in_byte == CH_N) begin
					nest_n = 1'b1;
					ph_n   = PH_QUALS;
				end else begin
					nest_n   = 1'b0;
					do_start = 1'b1;
				end
			end
			PH_QUALS: begin
				if (in_byte inside {CH_LV, CH_UV, CH_K}) begin
					ph_n = phase_q;
				end else if (in_byte inside {CH_C, CH_D, CH_E}) begin
					ph_n = PH_DONE;
				end else begin
					do_start = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (is_dig) begin
					dv_n = (acc > 20'h0FFFF) ? 16'hFFFF : acc[15:0];
				end else begin
					do_end = 1'b1;
				end
			end
			PH_TEXT:       do_text  = 1'b1;
			PH_AFTER_COMP: do_after = 1'b1;
			PH_DONE, PH_FAILED: ph_n = phase_q;
			default:       ph_n = PH_FAILED;
		endcase

		if (do_end) begin
			if (!room(ec_n, {1'b0, dv_n}, cap_q) || (nest_n && dv_n > 16'(COMP_MAX))) begin
				ph_n = PH_FAILED;
			end else begin
				bl_n   = dv_n;
				fill_n = '0;
				if (dv_n == 16'd0) begin
					if (nest_n) begin
						do_after = 1'b1;
					end else begin
						ph_n = PH_DONE;
					end
				end else begin
					ph_n    = PH_TEXT;
					do_text = 1'b1;
				end
			end
		end

		if (do_after) begin
			if (in_byte == CH_C || in_byte == CH_D) begin
				if (!room(ec_n, 17'd2, cap_q)) begin
					ph_n = PH_FAILED;
				end else begin
					c.col = 2'd2;
					ec_n  = ec_n + 16'd2;
					if (in_byte == CH_D && !room(ec_n, 17'd1, cap_q)) begin
						ph_n = PH_FAILED;
					end else begin
						if (in_byte == CH_D) begin
							c.tilde = 1'b1;
							ec_n    = ec_n + 16'd1;
						end
						if (!room(ec_n, 17'(fill_n), cap_q)) begin
							ph_n = PH_FAILED;
						end else begin
							c.rep_n = fill_n;
							ec_n    = ec_n + 16'(fill_n);
							ph_n    = PH_DONE;
						end
					end
				end
			end else if (in_byte == CH_E) begin
				ph_n = PH_DONE;
			end else begin
				do_start = 1'b1;
			end
		end

		if (do_start) begin
			if (nest_n && ec_n != 16'd0 && !room(ec_n, 17'd2, cap_q)) begin
				ph_n = PH_FAILED;
			end else begin
				if (nest_n && ec_n != 16'd0) begin
					c.col = 2'd2;
					ec_n  = ec_n + 16'd2;
				end
				if (is_dig) begin
					dv_n = {12'd0, dval};
					ph_n = PH_DIGITS;
				end else begin
					ph_n = PH_FAILED;
				end
			end
		end

		if (do_text) begin
			if (in_byte == CH_NUL) begin
				ph_n = PH_FAILED;
			end else begin
				c.ch_v = 1'b1;
				c.ch   = in_byte;
				ec_n   = ec_n + 16'd1;
				if (nest_n && fill_n < REP_W'(COMP_MAX)) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(fill_n);
					fill_n  = fill_n + 1'b1;
				end
				if (bl_n != 16'd0) begin
					bl_n = bl_n - 16'd1;
				end
				if (bl_n == 16'd0) begin
					ph_n = nest_n ? PH_AFTER_COMP : PH_DONE;
				end
			end
		end

		if (in_byte == CH_NUL) begin
			c.fin_v = 1'b1;
			c.fail  = (ph_n != PH_DONE);
			c.len   = (ph_n == PH_DONE) ? ec_n : 16'd0;
			ph_n    = PH_UNDERSCORE;
			dv_n    = '0;
			bl_n    = '0;
			ec_n    = '0;
			fill_n  = '0;
			nest_n  = 1'b0;
		end
	end

	assign has_out    = (c.col != 2'd0) || c.tilde || c.ch_v || (c.rep_n != '0) || c.fin_v;
	assign cmd        = c;
	assign cmd_push   = accept && has_out;
	assign st_wr.en   = accept && wr_en;
	assign st_wr.addr = wr_addr;
	assign st_wr.data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_UNDERSCORE;
			dv_q     <= '0;
			bl_q     <= '0;
			ec_q     <= '0;
			fill_q   <= '0;
			nest_q   <= 1'b0;
			cap_q    <= CAP_RESET;
			replay_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= ph_n;
				dv_q    <= dv_n;
				bl_q    <= bl_n;
				ec_q    <= ec_n;
				fill_q  <= fill_n;
				nest_q  <= nest_n;
			end
			if (cmd_push && c.rep_n != '0) begin
				replay_q <= 1'b1;
			end else if (bk_status.replay_done) begin
				replay_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/sdm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sdm_cmd_fifo
// Short command queue between parser and output sequencer.
// ----------------------------------------------------------------------------
module sdm_cmd_fifo import sdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic valid
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/sdm_back.sv
// ----------------------------------------------------------------------------
// sdm_back
// Output sequencer: expands queued commands into one result per cycle while the
// receiver takes them, replays the stored component and holds the output register.
// ----------------------------------------------------------------------------
module sdm_back import sdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	input  st_wr_t     st_wr,
	output bk_status_t bk_status,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_res
);

	logic [7:0]       store_q [COMP_MAX];
	cmd_t             wk_q, src, rem;
	logic [IDX_W-1:0] idx_q, src_idx, idx_n;
	logic             wk_busy, have_src, adv, rep_last;
	res_t             res, out_q;
	logic             out_valid_q;

	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			store_q[st_wr.addr] <= st_wr.data;
		end
	end

	assign wk_busy  = (wk_q.col != 2'd0) || wk_q.tilde || wk_q.ch_v ||
	                  (wk_q.rep_n != '0) || wk_q.fin_v;
	assign src      = wk_busy ? wk_q : head;
	assign src_idx  = wk_busy ? idx_q : '0;
	assign have_src = wk_busy || head_valid;
	assign adv      = have_src && (!out_valid_q || out_ready);
	assign pop      = adv && !wk_busy;

	always_comb begin
		rem      = src;
		idx_n    = src_idx;
		rep_last = 1'b0;
		res      = '0;
		if (src.col != 2'd0) begin
			res.data = CH_COLON;
			rem.col  = src.col - 2'd1;
		end else if (src.tilde) begin
			res.data  = CH_TILDE;
			rem.tilde = 1'b0;
		end else if (src.ch_v) begin
			res.data = src.ch;
			rem.ch_v = 1'b0;
		end else if (src.rep_n != '0) begin
			res.data  = store_q[src_idx];
			rem.rep_n = src.rep_n - 1'b1;
			idx_n     = src_idx + 1'b1;
			rep_last  = (src.rep_n == REP_W'(1));
		end else begin
			res.fin   = 1'b1;
			res.fail  = src.fail;
			res.len   = src.len;
			rem.fin_v = 1'b0;
		end
		res.last = !((rem.col != 2'd0) || rem.tilde || rem.ch_v ||
		             (rem.rep_n != '0) || rem.fin_v);
	end

	assign bk_status.replay_done = adv && rep_last;
	assign out_valid             = out_valid_q;
	assign out_res               = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				wk_q        <= rem;
				idx_q       <= idx_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/symbol_name_demangler.sv
// ----------------------------------------------------------------------------
// symbol_name_demangler
// Streaming demangler for a subset of mangled C++ symbol names.
//
// Usage:
//   s_axis carries one mangled byte per transfer; a zero byte ends the name.
//   m_axis carries the results: demangled characters, then one closing
//   status result per name (tuser high) with the failure flag and length.
//   tlast marks the last result caused by one input byte.
//   cfg_we/cfg_wdata write the output capacity (bytes, with terminator).
// Result path: with an empty queue the first result of a byte is written into
//   the command queue and then registered in the output register.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the receiver keeps up; the results of a byte leave the output one at a time,
//   absorbed by a four-entry command queue. A constructor or destructor replay
//   holds s_axis_tready low until the component store has been read out, which
//   also waits for any results still queued ahead and any receiver stall; the
//   replay reads one store entry per cycle while the receiver takes the results.
// Reset: parser returns to expecting the leading underscore, the queue and
//   output register empty, capacity 256.
// Receiver stall: the output register holds; the queue fills and then
//   s_axis_tready drops until results drain.
// ----------------------------------------------------------------------------
module symbol_name_demangler import sdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] failed, [24:9] name_length
	output logic        m_axis_tuser,   // [0] is_final
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	cmd_t       cmd, head;
	logic       cmd_push, fifo_full, pop, head_valid;
	bk_status_t bk_status;
	st_wr_t     st_wr;
	res_t       res;

	sdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.cmd_push  (cmd_push),
		.fifo_full (fifo_full),
		.bk_status (bk_status),
		.st_wr     (st_wr)
	);

	sdm_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.full   (fifo_full),
		.pop    (pop),
		.dout   (head),
		.valid  (head_valid)
	);

	sdm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.st_wr      (st_wr),
		.bk_status  (bk_status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {7'd0, res.len, res.fail, res.data};
	assign m_axis_tuser = res.fin;
	assign m_axis_tlast = res.last;

endmodule

FILE: dv/sdm_result_checker.sv
// ----------------------------------------------------------------------------
// sdm_result_checker
// Watches the byte stream, the result stream and the capacity writes of the
// symbol name demangler. Each accepted byte runs through a cycle-free model
// of the parser; the results it predicts are queued and every result
// transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module sdm_result_checker import sdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatches,
	output int          outstanding,
	output int          results_seen
);

	localparam int STEP_LIMIT = 36;

	typedef enum logic [3:0] {
		AWAIT_US, AWAIT_Z, AFTER_Z, QUALS, DIGITS, TEXT, AFTER_COMP, DONE, FAILED
	} phase_t;

	logic [15:0] capacity;
	phase_t      phase;
	logic [15:0] digit_acc;
	logic [15:0] text_left;
	logic [15:0] emitted;
	logic [7:0]  comp_store [COMP_MAX];
	int          comp_fill;
	logic        nested;

	res_t        step_buf [STEP_LIMIT];
	int          step_n;
	res_t        pending_results [$];
	int          err_n;
	int          seen_n;

	function automatic bit fits(int n);
		return int'(emitted) + n + 1 <= int'(capacity);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	task automatic put(logic [7:0] ch, logic fin, logic fail, logic [15:0] len);
		if (step_n < STEP_LIMIT) begin
			step_buf[step_n] = '{data: ch, fin: fin, fail: fail, len: len, last: 1'b0};
			step_n++;
		end
	endtask

	task automatic emit(logic [7:0] c);
		put(c, 1'b0, 1'b0, 16'd0);
		emitted = emitted + 16'd1;
	endtask

	task automatic open_component(logic [7:0] b);
		if (nested && emitted != 16'd0) begin
			if (!fits(2)) begin
				phase = FAILED;
				return;
			end
			emit(CH_COLON);
			emit(CH_COLON);
		end
		if (is_digit(b)) begin
			digit_acc = 16'(int'(b) - int'(CH_0));
			phase = DIGITS;
		end else begin
			phase = FAILED;
		end
	endtask

	task automatic close_component(logic [7:0] b);
		if (b == CH_C || b == CH_D) begin
			if (!fits(2)) begin
				phase = FAILED;
				return;
			end
			emit(CH_COLON);
			emit(CH_COLON);
			if (b == CH_D) begin
				if (!fits(1)) begin
					phase = FAILED;
					return;
				end
				emit(CH_TILDE);
			end
			if (!fits(comp_fill)) begin
				phase = FAILED;
				return;
			end
			for (int i = 0; i < comp_fill && i < COMP_MAX; i++)
				emit(comp_store[i]);
			phase = DONE;
		end else if (b == CH_E) begin
			phase = DONE;
		end else begin
			open_component(b);
		end
	endtask

	task automatic text_byte(logic [7:0] b);
		if (b == CH_NUL) begin
			phase = FAILED;
			return;
		end
		emit(b);
		if (nested && comp_fill < COMP_MAX) begin
			comp_store[comp_fill] = b;
			comp_fill++;
		end
		if (text_left > 16'd0)
			text_left = text_left - 16'd1;
		if (text_left == 16'd0)
			phase = nested ? AFTER_COMP : DONE;
	endtask

	task automatic end_length(logic [7:0] b);
		if (!fits(int'(digit_acc)) || (nested && int'(digit_acc) > COMP_MAX)) begin
			phase = FAILED;
			return;
		end
		text_left = digit_acc;
		comp_fill = 0;
		if (digit_acc == 16'd0) begin
			if (nested)
				close_component(b);
			else
				phase = DONE;
		end else begin
			phase = TEXT;
			text_byte(b);
		end
	endtask

	task automatic clear_parse();
		phase = AWAIT_US;
		digit_acc = 16'd0;
		text_left = 16'd0;
		emitted = 16'd0;
		comp_fill = 0;
		nested = 1'b0;
	endtask

	task automatic parse_byte(logic [7:0] b);
		int   v;
		logic ok;
		step_n = 0;
		case (phase)
			AWAIT_US: phase = (b == CH_US) ? AWAIT_Z : FAILED;
			AWAIT_Z: phase = (b == CH_Z) ? AFTER_Z : FAILED;
			AFTER_Z: begin
				if (b == CH_N) begin
					nested = 1'b1;
					phase = QUALS;
				end else begin
					nested = 1'b0;
					open_component(b);
				end
			end
			QUALS: begin
				if (!(b == CH_LV || b == CH_UV || b == CH_K)) begin
					if (b == CH_C || b == CH_D || b == CH_E)
						phase = DONE;
					else
						open_component(b);
				end
			end
			DIGITS: begin
				if (is_digit(b)) begin
					v = int'(digit_acc) * 10 + int'(b) - int'(CH_0);
					digit_acc = (v > 65535) ? 16'hFFFF : 16'(v);
				end else begin
					end_length(b);
				end
			end
			TEXT: text_byte(b);
			AFTER_COMP: close_component(b);
			DONE, FAILED: ;
			default: phase = FAILED;
		endcase
		if (b == CH_NUL) begin
			ok = (phase == DONE);
			put(CH_NUL, 1'b1, !ok, ok ? emitted : 16'd0);
			clear_parse();
		end
		if (step_n > 0)
			step_buf[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			pending_results.push_back(step_buf[i]);
	endtask

	task automatic check_result();
		res_t want;
		logic bad;
		seen_n++;
		if (pending_results.size() == 0) begin
			err_n++;
			if (err_n <= 10)
				$display("result %0d with nothing predicted: tdata %08h tuser %0b tlast %0b",
					seen_n, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			return;
		end
		want = pending_results.pop_front();
		bad = (m_axis_tdata[7:0] !== want.data) || (m_axis_tdata[8] !== want.fail) ||
			(m_axis_tdata[24:9] !== want.len) || (m_axis_tdata[31:25] !== 7'd0) ||
			(m_axis_tuser !== want.fin) || (m_axis_tlast !== want.last);
		if (bad) begin
			err_n++;
			if (err_n <= 10)
				$display({"result %0d: want byte %02h final %0b failed %0b length %0d last %0b,",
					" got byte %02h final %0b failed %0b length %0d last %0b pad %02h"},
					seen_n, want.data, want.fin, want.fail, want.len, want.last,
					m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[8], m_axis_tdata[24:9],
					m_axis_tlast, m_axis_tdata[31:25]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = CAP_RESET;
			clear_parse();
			pending_results.delete();
			err_n = 0;
			seen_n = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			mismatches <= err_n;
			outstanding <= pending_results.size();
			results_seen <= seen_n;
		end
	end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Top of the symbol name demangler test. Sends directed names covering
// plain, nested, constructor and destructor forms, qualifiers, malformed
// input and output overflow, then random names under several capacities,
// with random gaps on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import sdm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	int          mismatches;
	int          outstanding;
	int          results_seen;

	bit          steady;
	int          bytes_sent;
	int          names_sent;
	int          cap_writes;
	logic [7:0]  name_q [$];

	symbol_name_demangler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	sdm_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[symbol_name_demangler] ERROR");
		$finish;
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_name();
		name_q.push_back(CH_NUL);
		foreach (name_q[i])
			send_byte(name_q[i]);
		name_q.delete();
		names_sent++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			name_q.push_back(s[i]);
	endtask

	task automatic add_text(int n);
		repeat (n) name_q.push_back(8'($urandom_range(1, 255)));
	endtask

	task automatic add_component(int n);
		if ($urandom_range(0, 9) == 0)
			add_str("0");
		add_str($sformatf("%0d", n));
		add_text(n);
	endtask

	task automatic settle();
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cap_writes++;
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 6);
		else if (r < 97)
			return $urandom_range(7, 32);
		return $urandom_range(33, 40);
	endfunction

	task automatic build_nested();
		int    r;
		string q;
		add_str("_ZN");
		repeat ($urandom_range(0, 3)) begin
			r = $urandom_range(0, 2);
			q = (r == 0) ? "v" : (r == 1) ? "V" : "K";
			add_str(q);
		end
		repeat ($urandom_range(1, 3)) add_component(pick_length());
		r = $urandom_range(0, 9);
		if (r < 3)
			add_str("C");
		else if (r < 6)
			add_str("D");
		else if (r < 9)
			add_str("E");
	endtask

	task automatic build_random_name();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			build_nested();
		end else if (r < 75) begin
			add_str("_Z");
			add_component(pick_length());
			if ($urandom_range(0, 4) == 0)
				add_text($urandom_range(1, 4));
		end else if (r < 85) begin
			build_nested();
			k = $urandom_range(0, name_q.size() - 1);
			name_q[k] = 8'($urandom_range(0, 255));
		end else if (r < 93) begin
			build_nested();
			k = $urandom_range(1, name_q.size());
			while (name_q.size() > k)
				void'(name_q.pop_back());
		end else begin
			repeat ($urandom_range(0, 8)) name_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic directed_names();
		string names [] = '{"_Z3abc", "_ZN3foo3barE", "_ZNVKv4BaseC", "_ZN1x3TagD",
			"_ZNE", "_ZNKC", "_ZNVD", "_Zq", "_ZN1a#", "_Z99999", "_ZN33a", "_Z2a",
			"_Z1abcE", "_ZN0E", "_ZN01a1bE", "_ZN0D", "X", "_Y", ""};
		write_capacity(CAP_RESET);
		foreach (names[i]) begin
			add_str(names[i]);
			send_name();
		end
		add_str("_Z1");
		name_q.push_back(8'hFF);
		send_name();
		add_str("_ZN2");
		name_q.push_back(8'h80);
		name_q.push_back(8'h7F);
		add_str("E");
		send_name();
		add_str("_Z40");
		add_text(40);
		send_name();
		add_str("_ZN32");
		add_text(32);
		add_str("D");
		send_name();
		write_capacity(16'd1);
		add_str("_ZN0E");
		send_name();
		add_str("_Z1a");
		send_name();
		write_capacity(16'd4);
		add_str("_ZN1a1bE");
		send_name();
		add_str("_ZN1aD");
		send_name();
		write_capacity(16'hFFFF);
		add_str("_ZN5abcdeC");
		send_name();
	endtask

	initial begin
		logic [15:0] caps [5];
		int goal;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		steady = 1'b0;
		bytes_sent = 0;
		names_sent = 0;
		cap_writes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_names();

		caps[0] = CAP_RESET;
		caps[1] = 16'hFFFF;
		caps[2] = 16'($urandom_range(2, 24));
		caps[3] = 16'd1;
		caps[4] = 16'($urandom_range(8, 80));
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			goal = bytes_sent + 8;
			while (bytes_sent < goal) begin
				steady = ($urandom_range(0, 3) == 0);
				build_random_name();
				send_name();
			end
		end
		steady = 1'b0;
		settle();

		$display("sent %0d names in %0d bytes under %0d capacity settings",
			names_sent, bytes_sent, cap_writes);
		$display("checked %0d results, %0d mismatches, %0d never arrived",
			results_seen, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("[symbol_name_demangler] OK");
		else
			$display("[symbol_name_demangler] ERROR");
		$finish;
	end

endmodule
